>>> hw/rtl/msb_first_bit_field_packer_core_defines.svh
// assertion macros used by the packer core rtl
`ifndef MSB_FIRST_BIT_FIELD_PACKER_CORE_DEFINES_SVH
`define MSB_FIRST_BIT_FIELD_PACKER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define BFP_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bit field packer check failed");

// next-cycle implication, sampled on clock, off during reset
`define BFP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bit field packer check failed");

`endif

>>> hw/rtl/bfpack_pkg.sv
// types and codes of the msb-first bit field packer
package bfpack_pkg;

   localparam int FIELD_MAX_W = 32;
   localparam int WIDTH_W     = 6;
   localparam int POS_W       = 12;

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_READ  = 2'd1,
      ACT_SEEK  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_WIDTH = 2'd1,
      ST_TOO_LARGE = 2'd2,
      ST_OVERRUN   = 2'd3
   } status_type;

   typedef struct packed {
      action_type               action;
      logic [FIELD_MAX_W-1:0]   field_value;
      logic [WIDTH_W-1:0]       field_width;
      logic [POS_W-1:0]         seek_position;
   } req_type;

   typedef struct packed {
      logic [FIELD_MAX_W-1:0]   read_value;
      status_type               status;
      logic [POS_W-1:0]         cursor_after;
   } rsp_type;

endpackage

>>> hw/rtl/bfpack_stream_if.sv
// valid/ready channel carrying one payload per transfer
interface bfpack_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/bfpack_ram.sv
// generic single-write single-read ram with registered read data
module bfpack_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hw/rtl/msb_first_bit_field_packer_core.sv
// msb-first bit field packer: byte store, bit cursor, byte-serial read-modify-write
//
//   channel   dir   transfer moves
//   req_chan  in    action, field_value, field_width, seek_position
//   rsp_chan  out   read_value, status, cursor_after
//
// each touched byte is read, then merged and written back (write) or shifted into the read value
// (read) through the single ram port pair; a 32-bit field touches up to 5 bytes
// seeks, errors and the unused action go from the check straight to the response hand-off
// after reset the store is zeroed one byte a cycle, with req ready low until it is done
// a finished response waits in the output register; the next request is taken meanwhile,
// and the block stalls only at its own finish while that register is still full
module msb_first_bit_field_packer_core #(
   parameter int BUFFER_BYTES = 256
) (
   input  logic            clock,
   input  logic            reset,
   bfpack_stream_if.sink   req_chan,
   bfpack_stream_if.source rsp_chan
);
   `include "msb_first_bit_field_packer_core_defines.svh"

   localparam int TOTAL_BITS = BUFFER_BYTES * 8;
   localparam int AW         = $clog2(BUFFER_BYTES);
   localparam int CW         = $clog2(TOTAL_BITS + 1);
   localparam int XW         = ((CW > bfpack_pkg::POS_W) ? CW : bfpack_pkg::POS_W) + 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(BUFFER_BYTES - 1);
   localparam logic [XW-1:0] TOTAL_X   = XW'(TOTAL_BITS);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_FETCH,
      S_MERGE,
      S_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [AW-1:0]          clr_addr_ff, clr_addr_in;
   logic [CW-1:0]          cursor_ff, cursor_in;
   bfpack_pkg::req_type    req_ff, req_in;
   logic [CW-1:0]          pos_ff, pos_in;
   logic [5:0]             rem_ff, rem_in;
   logic [31:0]            sr_ff, sr_in;
   logic [31:0]            rd_ff, rd_in;
   bfpack_pkg::status_type stat_ff, stat_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   bfpack_pkg::rsp_type    rsp_ff, rsp_in;

   // checks
   logic bad_wid, too_big, over_fld, seek_over;

   // byte merge unit
   logic [2:0] off;
   logic [3:0] room, n;
   logic [7:0] lo_mask, mask, new_byte, byte_al, chunk;

   // ram ports
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]    ram_wdata, ram_rdata;

   assign bad_wid  = (req_ff.field_width == '0) || (req_ff.field_width > 6'd32);
   assign too_big  = (req_ff.field_width < 6'd32) &&
                     ((req_ff.field_value >> req_ff.field_width) != '0);
   assign over_fld = (XW'(cursor_ff) + XW'(req_ff.field_width)) > TOTAL_X;
   assign seek_over = XW'(req_ff.seek_position) > TOTAL_X;

   assign off      = pos_ff[2:0];
   assign room     = 4'd8 - {1'b0, off};
   assign n        = (rem_ff < {2'b00, room}) ? rem_ff[3:0] : room;
   assign lo_mask  = 8'hFF << (4'd8 - n);
   assign mask     = lo_mask >> off;
   assign new_byte = (ram_rdata & ~mask) | ((sr_ff[31:24] >> off) & mask);
   assign byte_al  = ram_rdata << off;
   assign chunk    = byte_al >> (4'd8 - n);

   assign ram_raddr = pos_ff[AW+2:3];

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      cursor_in    = cursor_ff;
      req_in       = req_ff;
      pos_in       = pos_ff;
      rem_in       = rem_ff;
      sr_in        = sr_ff;
      rd_in        = rd_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = ram_raddr;
      ram_wdata    = new_byte;

      case (state_ff)
         S_CLEAR: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            ram_wdata   = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_chan.valid) begin
               req_in   = req_chan.payload;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            rd_in    = '0;
            stat_in  = bfpack_pkg::ST_OK;
            state_in = S_DONE;
            case (req_ff.action)
               bfpack_pkg::ACT_WRITE: begin
                  if (bad_wid) begin
                     stat_in = bfpack_pkg::ST_BAD_WIDTH;
                  end else if (too_big) begin
                     stat_in = bfpack_pkg::ST_TOO_LARGE;
                  end else if (over_fld) begin
                     stat_in = bfpack_pkg::ST_OVERRUN;
                  end else begin
                     state_in = S_FETCH;
                  end
               end
               bfpack_pkg::ACT_READ: begin
                  if (bad_wid) begin
                     stat_in = bfpack_pkg::ST_BAD_WIDTH;
                  end else if (over_fld) begin
                     stat_in = bfpack_pkg::ST_OVERRUN;
                  end else begin
                     state_in = S_FETCH;
                  end
               end
               bfpack_pkg::ACT_SEEK: begin
                  if (seek_over) begin
                     stat_in = bfpack_pkg::ST_OVERRUN;
                  end else begin
                     cursor_in = CW'(req_ff.seek_position);
                  end
               end
               default: begin
               end
            endcase
            // field left-aligned so the next bits to place sit at the top
            pos_in = cursor_ff;
            rem_in = req_ff.field_width;
            sr_in  = req_ff.field_value << (6'd32 - req_ff.field_width);
         end
         S_FETCH: begin
            state_in = S_MERGE;
         end
         S_MERGE: begin
            ram_we = (req_ff.action == bfpack_pkg::ACT_WRITE);
            pos_in = pos_ff + CW'(n);
            rem_in = rem_ff - 6'(n);
            sr_in  = sr_ff << n;
            if (req_ff.action == bfpack_pkg::ACT_READ) begin
               rd_in = (rd_ff << n) | 32'(chunk);
            end
            if (rem_ff == 6'(n)) begin
               cursor_in = pos_ff + CW'(n);
               state_in  = S_DONE;
            end else begin
               state_in = S_FETCH;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in        = 1'b1;
               rsp_in.read_value   = rd_ff;
               rsp_in.status       = stat_ff;
               rsp_in.cursor_after = bfpack_pkg::POS_W'(cursor_ff);
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff  <= req_in;
      pos_ff  <= pos_in;
      rem_ff  <= rem_in;
      sr_ff   <= sr_in;
      rd_ff   <= rd_in;
      stat_ff <= stat_in;
      rsp_ff  <= rsp_in;
   end

   bfpack_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_chan.ready  = (state_ff == S_IDLE);
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   `BFP_ASSERT_SAME(a_cursor_in_store, 1'b1, XW'(cursor_ff) <= TOTAL_X)
   `BFP_ASSERT_SAME(a_chunk_fits, state_ff == S_MERGE, 6'(n) <= rem_ff)
   `BFP_ASSERT_SAME(a_data_only_ok, rsp_valid_ff && (rsp_ff.read_value != '0),
                    rsp_ff.status == bfpack_pkg::ST_OK)
   `BFP_ASSERT_NEXT(a_done_posts, (state_ff == S_DONE) && !rsp_valid_ff, rsp_valid_ff)
endmodule

>>> tb/sv/tb_top.sv
// testbench for the msb-first bit field packer: directed and random actions, checked per transfer
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BUFFER_BYTES = 256;
   localparam int TOTAL_BITS   = BUFFER_BYTES * 8;
   localparam int HOLD_CYCLES  = 400;
   localparam int WATCHDOG_MAX = 4000;
   localparam int PHASE_ITEMS  = 430;
   localparam int SETTLE       = 20;
   localparam int FIELD_MAX_W  = bfpack_pkg::FIELD_MAX_W;
   localparam int WIDTH_W      = bfpack_pkg::WIDTH_W;
   localparam int POS_W        = bfpack_pkg::POS_W;
   localparam bfpack_pkg::action_type ACT_UNUSED = bfpack_pkg::action_type'(2'd3);

   // expected responses from a private copy of the store and cursor
   class field_packer_scoreboard;
      logic [7:0]          store_bytes [BUFFER_BYTES];
      int unsigned         cursor;
      bfpack_pkg::rsp_type awaited_responses [$];
      int                  mismatches;
      int                  checked;
      int                  status_seen [4];

      function new();
         foreach (store_bytes[i]) store_bytes[i] = '0;
         foreach (status_seen[i]) status_seen[i] = 0;
         cursor     = 0;
         mismatches = 0;
         checked    = 0;
      endfunction

      function bfpack_pkg::rsp_type apply_action(bfpack_pkg::req_type r);
         bfpack_pkg::rsp_type res;
         int unsigned         w;
         int unsigned         p;
         res.read_value = '0;
         res.status     = bfpack_pkg::ST_OK;
         w = r.field_width;
         case (r.action)
            bfpack_pkg::ACT_WRITE, bfpack_pkg::ACT_READ: begin
               if (w == 0 || w > FIELD_MAX_W)
                  res.status = bfpack_pkg::ST_BAD_WIDTH;
               else if (r.action == bfpack_pkg::ACT_WRITE && w < FIELD_MAX_W &&
                        (r.field_value >> w) != 0)
                  res.status = bfpack_pkg::ST_TOO_LARGE;
               else if (cursor + w > TOTAL_BITS)
                  res.status = bfpack_pkg::ST_OVERRUN;
               else begin
                  // cursor bit 0 is bit 7 of byte 0
                  for (int i = 0; i < w; i++) begin
                     p = cursor + i;
                     if (r.action == bfpack_pkg::ACT_WRITE)
                        store_bytes[p / 8][7 - p % 8] = r.field_value[w - 1 - i];
                     else
                        res.read_value = {res.read_value[FIELD_MAX_W-2:0],
                                          store_bytes[p / 8][7 - p % 8]};
                  end
                  cursor += w;
               end
            end
            bfpack_pkg::ACT_SEEK: begin
               if (r.seek_position > TOTAL_BITS)
                  res.status = bfpack_pkg::ST_OVERRUN;
               else
                  cursor = r.seek_position;
            end
            default: ;
         endcase
         res.cursor_after = POS_W'(cursor);
         return res;
      endfunction

      function void note_request(bfpack_pkg::req_type r);
         awaited_responses.push_back(apply_action(r));
      endfunction

      function int pending();
         return awaited_responses.size();
      endfunction

      task report(string what);
         mismatches++;
         if (mismatches <= 40)
            $display("tb_top: mismatch at %0t: %s", $realtime, what);
      endtask

      task check_response(bfpack_pkg::rsp_type got);
         bfpack_pkg::rsp_type want;
         if (awaited_responses.size() == 0) begin
            report("response transfer with nothing awaited");
            return;
         end
         want = awaited_responses.pop_front();
         checked++;
         status_seen[want.status]++;
         if (got.read_value !== want.read_value)
            report($sformatf("read_value %h, expected %h", got.read_value, want.read_value));
         if (got.status !== want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
         if (got.cursor_after !== want.cursor_after)
            report($sformatf("cursor_after %0d, expected %0d",
                             got.cursor_after, want.cursor_after));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   bfpack_stream_if #(.payload_type(bfpack_pkg::req_type)) req_chan ();
   bfpack_stream_if #(.payload_type(bfpack_pkg::rsp_type)) rsp_chan ();

   msb_first_bit_field_packer_core #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   field_packer_scoreboard sb = new();

   int   sent        = 0;
   int   stall_pct   = 0;
   logic hold_toggle = 1'b0;

   function automatic bfpack_pkg::req_type make_req(bfpack_pkg::action_type a,
                                                    logic [31:0] v, int w, int s);
      bfpack_pkg::req_type r;
      r.action        = a;
      r.field_value   = v;
      r.field_width   = WIDTH_W'(w);
      r.seek_position = POS_W'(s);
      return r;
   endfunction

   // mostly well-formed fields at the cursor, with seeks and some malformed actions
   function automatic bfpack_pkg::req_type random_request();
      bfpack_pkg::req_type r;
      int unsigned         pick;
      int unsigned         w;
      r.action        = bfpack_pkg::ACT_WRITE;
      r.field_value   = $urandom;
      r.field_width   = WIDTH_W'($urandom_range(63));
      r.seek_position = POS_W'($urandom_range(4095));
      pick = $urandom_range(99);
      if (pick < 45) begin
         w = $urandom_range(1, 32);
         r.field_width = WIDTH_W'(w);
         if (w < 32)
            r.field_value = r.field_value & ((32'd1 << w) - 1);
      end else if (pick < 75) begin
         r.action      = bfpack_pkg::ACT_READ;
         r.field_width = WIDTH_W'($urandom_range(1, 32));
      end else if (pick < 88) begin
         r.action = bfpack_pkg::ACT_SEEK;
         case ($urandom_range(3))
            0:       r.seek_position = POS_W'(TOTAL_BITS - $urandom_range(40));
            1:       r.seek_position = POS_W'($urandom_range(40));
            default: r.seek_position = POS_W'($urandom_range(TOTAL_BITS));
         endcase
      end else begin
         case ($urandom_range(3))
            0: begin
               r.action      = $urandom_range(1) ? bfpack_pkg::ACT_WRITE
                                                 : bfpack_pkg::ACT_READ;
               r.field_width = $urandom_range(1) ? WIDTH_W'(0)
                                                 : WIDTH_W'($urandom_range(33, 63));
            end
            1: begin
               w = $urandom_range(1, 31);
               r.field_width = WIDTH_W'(w);
               r.field_value = r.field_value | (32'd1 << $urandom_range(w, 31));
            end
            2: begin
               r.action        = bfpack_pkg::ACT_SEEK;
               r.seek_position = POS_W'($urandom_range(TOTAL_BITS + 1, 4095));
            end
            default: r.action = ACT_UNUSED;
         endcase
      end
      return r;
   endfunction

   // called at a rising edge; returns at the edge where the transfer happened
   task automatic send_request(input bfpack_pkg::req_type r, input int idle_pct);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= r;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(r);
      sent++;
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // receiver: random stalls plus a long hold-off on request
   initial begin
      int   hold_left;
      logic hold_seen;
      hold_left = 0;
      hold_seen = 1'b0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_response(rsp_chan.payload);
         if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
         end
         @(posedge clock);
      end
   end

   // watchdog on cycles without any transfer
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= WATCHDOG_MAX) begin
            $display("tb_top: no transfer for %0d cycles", quiet);
            $display("tb_top: done, errors");
            $finish;
         end
      end
   end

   initial begin
      bfpack_pkg::req_type directed [$];
      int                  sender_pct [4];
      int                  receiver_pct [4];
      sender_pct   = '{0, 76, 0, 24};
      receiver_pct = '{0, 0, 76, 24};
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;

      // fresh store, all-ones field, single bits, then read back
      directed.push_back(make_req(bfpack_pkg::ACT_READ,  32'h0,        32, 0));
      directed.push_back(make_req(bfpack_pkg::ACT_SEEK,  32'h0,        0,  0));
      directed.push_back(make_req(bfpack_pkg::ACT_WRITE, 32'hFFFFFFFF, 32, 0));
      directed.push_back(make_req(bfpack_pkg::ACT_WRITE, 32'h1,        1,  0));
      directed.push_back(make_req(bfpack_pkg::ACT_WRITE, 32'h0,        1,  0));
      directed.push_back(make_req(bfpack_pkg::ACT_WRITE, 32'h5,        3,  0));
      directed.push_back(make_req(bfpack_pkg::ACT_SEEK,  32'h0,        0,  0));
      directed.push_back(make_req(bfpack_pkg::ACT_READ,  32'h0,        32, 0));
      directed.push_back(make_req(bfpack_pkg::ACT_READ,  32'h0,        5,  0));
      // bad widths, value too large, and bad width taking precedence
      directed.push_back(make_req(bfpack_pkg::ACT_WRITE, 32'h0,        0,  0));
      directed.push_back(make_req(bfpack_pkg::ACT_WRITE, 32'h0,        33, 0));
      directed.push_back(make_req(bfpack_pkg::ACT_WRITE, 32'hFFFFFFFF, 63, 0));
      directed.push_back(make_req(bfpack_pkg::ACT_READ,  32'h0,        0,  0));
      directed.push_back(make_req(bfpack_pkg::ACT_WRITE, 32'h100,      8,  0));
      directed.push_back(make_req(bfpack_pkg::ACT_WRITE, 32'hFFFFFFFF, 0,  0));
      // end of store: overrun, and value check ahead of overrun
      directed.push_back(make_req(bfpack_pkg::ACT_SEEK,  32'h0,        0,  TOTAL_BITS));
      directed.push_back(make_req(bfpack_pkg::ACT_WRITE, 32'h1,        1,  0));
      directed.push_back(make_req(bfpack_pkg::ACT_WRITE, 32'h1F,       4,  0));
      directed.push_back(make_req(bfpack_pkg::ACT_READ,  32'h0,        1,  0));
      directed.push_back(make_req(bfpack_pkg::ACT_SEEK,  32'h0,        0,  TOTAL_BITS + 1));
      directed.push_back(make_req(bfpack_pkg::ACT_SEEK,  32'h0,        0,  4095));
      directed.push_back(make_req(ACT_UNUSED,            32'hFFFFFFFF, 63, 4095));
      // a word near the end of the store written unaligned and read back
      directed.push_back(make_req(bfpack_pkg::ACT_SEEK,  32'h0,        0,  TOTAL_BITS - 35));
      directed.push_back(make_req(bfpack_pkg::ACT_WRITE, 32'hA5C3_0F96, 32, 0));
      directed.push_back(make_req(bfpack_pkg::ACT_SEEK,  32'h0,        0,  TOTAL_BITS - 35));
      directed.push_back(make_req(bfpack_pkg::ACT_READ,  32'h0,        32, 0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_request(directed[i], 0);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         stall_pct = receiver_pct[phase];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 0 && n == 150)
               hold_toggle <= ~hold_toggle;
            send_request(random_request(), sender_pct[phase]);
         end
         drain();
      end

      repeat (SETTLE) @(posedge clock);
      $display("tb_top: %0d requests, %0d responses: ok %0d, bad width %0d,",
               sent, sb.checked, sb.status_seen[bfpack_pkg::ST_OK],
               sb.status_seen[bfpack_pkg::ST_BAD_WIDTH]);
      $display("tb_top: too large %0d, overrun %0d; phases without stalls, sender idle,",
               sb.status_seen[bfpack_pkg::ST_TOO_LARGE], sb.status_seen[bfpack_pkg::ST_OVERRUN]);
      $display("tb_top: receiver stalls, both; one long hold-off");
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
